FILE: hdl/rmq_pkg.sv
`default_nettype none
package rmq_pkg;
  localparam int MaxElements = 1024;
  localparam int IdxW = 10;
  localparam int CntW = 11;
  localparam int ValW = 32;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef struct packed {
    logic load;
    logic q_start;
    logic rd_en;
    logic cmp;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic q_ok;
    logic at_end;
  } sts_t;
endpackage
`default_nettype wire

FILE: hdl/rmq_datapath.sv
`default_nettype none
module rmq_datapath (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire  rmq_pkg::cmd_t                cmd_i,
  output rmq_pkg::sts_t                      sts_o,
  input  wire  [rmq_pkg::ValW-1:0]           value_i,
  input  wire                                last_i,
  input  wire  [rmq_pkg::IdxW-1:0]           index_a_i,
  input  wire  [rmq_pkg::IdxW-1:0]           index_b_i,
  output logic                               valid_res_o,
  output logic [rmq_pkg::IdxW-1:0]           min_index_o,
  output logic signed [rmq_pkg::ValW-1:0]    min_value_o
);
  logic [rmq_pkg::ValW-1:0] mem [rmq_pkg::MaxElements];
  logic [rmq_pkg::CntW-1:0] count_q, cnt_base;
  logic                     built_q;
  logic [rmq_pkg::IdxW-1:0] ptr_q, hi_q, lo, hi;
  logic signed [rmq_pkg::ValW-1:0] rdata_q;
  logic                     first_q;

  assign cnt_base = built_q ? '0 : count_q;
  assign lo = (index_a_i < index_b_i) ? index_a_i : index_b_i;
  assign hi = (index_a_i < index_b_i) ? index_b_i : index_a_i;

  assign sts_o.q_ok = built_q && ({1'b0, index_a_i} < count_q) && ({1'b0, index_b_i} < count_q);
  assign sts_o.at_end = (ptr_q == hi_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      built_q <= 1'b0;
    end else if (cmd_i.load) begin
      if (cnt_base < rmq_pkg::CntW'(rmq_pkg::MaxElements)) begin
        count_q <= cnt_base + 1'b1;
      end else begin
        count_q <= cnt_base;
      end
      built_q <= last_i;
    end
  end

  // element store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (cnt_base < rmq_pkg::CntW'(rmq_pkg::MaxElements))) begin
      mem[cnt_base[rmq_pkg::IdxW-1:0]] <= value_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[ptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_start) begin
      ptr_q       <= lo;
      hi_q        <= hi;
      first_q     <= 1'b1;
      valid_res_o <= sts_o.q_ok;
      min_index_o <= '0;
      min_value_o <= '0;
    end else begin
      if (cmd_i.cmp) begin
        first_q <= 1'b0;
        // strict less keeps the leftmost minimum
        if (first_q || (rdata_q < min_value_o)) begin
          min_value_o <= rdata_q;
          min_index_o <= ptr_q;
        end
      end
      if (cmd_i.step) begin
        ptr_q <= ptr_q + 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

FILE: hdl/rmq_ctrl.sv
`default_nettype none
module rmq_ctrl (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            start_i,
  input  wire            operation_i,
  input  wire  rmq_pkg::sts_t sts_i,
  output rmq_pkg::cmd_t  cmd_o,
  output logic           busy_o,
  output logic           done_o
);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StCmp  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign accept = start_i && (state_q == StIdle);
  assign busy_o = (state_q != StIdle);
  assign done_o = (state_q == StOut);

  always_comb begin
    cmd_o         = '0;
    state_d       = state_q;
    cmd_o.load    = accept && (operation_i == rmq_pkg::OpLoad);
    cmd_o.q_start = accept && (operation_i == rmq_pkg::OpQuery);
    unique case (state_q)
      StIdle: begin
        if (cmd_o.q_start) begin
          state_d = sts_i.q_ok ? StRead : StOut;
        end
      end
      StRead: begin
        cmd_o.rd_en = 1'b1;
        state_d     = StCmp;
      end
      StCmp: begin
        cmd_o.cmp = 1'b1;
        if (sts_i.at_end) begin
          state_d = StOut;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = StRead;
        end
      end
      StOut: begin
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
`default_nettype wire

FILE: hdl/range_minimum_query.sv
`default_nettype none
// channel   ports                                          handshake
// input     operation_i value_i last_i index_a_i index_b_i start_i && !busy_o
// result    valid_res_o min_index_o min_value_o            done_o, one cycle
//
// a load item gives no result; busy_o stays low
// a query with range lo..hi does one memory read
// and one compare per element over the single store read port
// an invalid query goes straight to the result strobe; reset clears count, built flag and sequencer state only
// results cannot be stalled; done_o is high for exactly one cycle
module range_minimum_query (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             start_i,
  output logic                            busy_o,
  output logic                            done_o,
  input  wire                             operation_i,
  input  wire  signed [rmq_pkg::ValW-1:0] value_i,
  input  wire                             last_i,
  input  wire  [rmq_pkg::IdxW-1:0]        index_a_i,
  input  wire  [rmq_pkg::IdxW-1:0]        index_b_i,
  output logic                            valid_res_o,
  output logic [rmq_pkg::IdxW-1:0]        min_index_o,
  output logic signed [rmq_pkg::ValW-1:0] min_value_o
);
  rmq_pkg::cmd_t cmd;
  rmq_pkg::sts_t sts;

  // sequencer: idle, read, compare, result strobe
  rmq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .operation_i (operation_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy_o),
    .done_o      (done_o)
  );

  // element store, load count and scan registers
  rmq_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .value_i     (value_i),
    .last_i      (last_i),
    .index_a_i   (index_a_i),
    .index_b_i   (index_b_i),
    .valid_res_o (valid_res_o),
    .min_index_o (min_index_o),
    .min_value_o (min_value_o)
  );

`ifndef SYNTH
  a_done_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result strobe outside a query");
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !valid_res_o) |-> (min_value_o == 0 && min_index_o == 0))
    else $error("invalid result not zero");
  a_load_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && operation_i == rmq_pkg::OpLoad) |=> !busy_o)
    else $error("load item made block busy");
`endif
endmodule
`default_nettype wire
